// File: rtl/ry420_pkg.sv
// ----------------------------------------------------------------------------
// ry420_pkg
// Shared types, codes and constants of the RGB to YCbCr 4:2:0 planar unit.
// ----------------------------------------------------------------------------
package ry420_pkg;

  localparam int CFG_W        = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int COMP_W       = 8;
  localparam int OFFSET_W     = 25;
  localparam int CHROMA_IDX_W = 22;

  localparam int DEFAULT_MAX_WIDTH  = 4096;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // JFIF coefficients, 16 fractional bits
  localparam logic [15:0]        K_Y_R = 16'd19595;
  localparam logic [15:0]        K_Y_G = 16'd38470;
  localparam logic [15:0]        K_Y_B = 16'd7471;
  localparam logic signed [17:0] K_CB  = 18'sd36962;
  localparam logic signed [17:0] K_CR  = 18'sd46727;
  localparam logic signed [11:0] CHROMA_BIAS = 12'sd128;

  typedef enum logic [1:0] {
    PLANE_Y  = 2'd0,
    PLANE_CB = 2'd1,
    PLANE_CR = 2'd2
  } plane_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT_Y,
    ST_EMIT_CB,
    ST_EMIT_CR
  } state_t;

  typedef struct packed {
    logic   pixel_ready;
    logic   load_pixel;
    logic   load_chroma;
    logic   load_out;
    plane_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic chroma;
    logic slot_free;
  } dp_status_t;

endpackage

// File: rtl/ry420_pixel_if.sv
// ----------------------------------------------------------------------------
// ry420_pixel_if
// Input pixel channel: one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface ry420_pixel_if;
  import ry420_pkg::*;

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// File: rtl/ry420_result_if.sv
// ----------------------------------------------------------------------------
// ry420_result_if
// Result channel: one plane sample with its byte offset per transfer.
// ----------------------------------------------------------------------------
interface ry420_result_if;
  import ry420_pkg::*;

  logic                valid;
  logic                ready;
  plane_t              plane;
  logic [OFFSET_W-1:0] offset;
  logic [COMP_W-1:0]   sample;
  logic                last;
  logic                frame_done;

  modport source (output valid, plane, offset, sample, last, frame_done, input ready);
  modport sink   (input valid, plane, offset, sample, last, frame_done, output ready);
endinterface

// File: rtl/ry420_cfg_if.sv
// ----------------------------------------------------------------------------
// ry420_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ry420_cfg_if;
  import ry420_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ry420_ctrl.sv
// ----------------------------------------------------------------------------
// ry420_ctrl
// Sequencer: accepts pixels and steps the result register through the
// Y transfer of each pixel and the Cb and Cr transfers of each chroma pixel.
// ----------------------------------------------------------------------------
module ry420_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pixel_valid,
  input  ry420_pkg::dp_status_t status,
  output ry420_pkg::dp_cmd_t    cmd
);
  import ry420_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd.pixel_ready = 1'b0;
    cmd.load_pixel  = 1'b0;
    cmd.load_chroma = 1'b0;
    cmd.load_out    = 1'b0;
    cmd.out_sel     = PLANE_Y;
    case (state)
      ST_IDLE: begin
        cmd.pixel_ready = 1'b1;
        if (pixel_valid) begin
          cmd.load_pixel = 1'b1;
          state_next     = ST_EMIT_Y;
        end
      end
      ST_EMIT_Y: begin
        cmd.load_chroma = 1'b1;
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = PLANE_Y;
          if (status.chroma) begin
            state_next = ST_EMIT_CB;
          end else begin
            cmd.pixel_ready = 1'b1;
            cmd.load_pixel  = pixel_valid;
            state_next      = pixel_valid ? ST_EMIT_Y : ST_IDLE;
          end
        end
      end
      ST_EMIT_CB: begin
        if (status.slot_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = PLANE_CB;
          state_next   = ST_EMIT_CR;
        end
      end
      ST_EMIT_CR: begin
        if (status.slot_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_sel     = PLANE_CR;
          cmd.pixel_ready = 1'b1;
          cmd.load_pixel  = pixel_valid;
          state_next      = pixel_valid ? ST_EMIT_Y : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/ry420_datapath.sv
// ----------------------------------------------------------------------------
// ry420_datapath
// Frame size registers, raster counters, color conversion and the
// result register.
// ----------------------------------------------------------------------------
module ry420_datapath #(
  parameter int MAX_WIDTH  = ry420_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ry420_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  ry420_cfg_if.sink                     cfg,
  input  logic [ry420_pkg::COMP_W-1:0]  red,
  input  logic [ry420_pkg::COMP_W-1:0]  green,
  input  logic [ry420_pkg::COMP_W-1:0]  blue,
  ry420_result_if.source                result,
  input  ry420_pkg::dp_cmd_t            cmd,
  output ry420_pkg::dp_status_t         status
);
  import ry420_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int EHW = (HW > CFG_W) ? HW : CFG_W;

  function automatic logic [COMP_W-1:0] clip_sample(input logic signed [11:0] v);
    logic [COMP_W-1:0] r;
    if (v < 12'sd0) begin
      r = '0;
    end else if (v > 12'sd255) begin
      r = '1;
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_write;

  logic [EWW-1:0] w_ext;
  logic [EHW-1:0] h_ext;
  logic [EWW-1:0] w_clamp;
  logic [EHW-1:0] h_clamp;
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;

  logic [WW+HW-1:0]  area;
  logic [OFFSET_W-1:0] cb_base;
  logic [OFFSET_W-1:0] cr_base;

  logic [CLW-1:0]          column;
  logic [RW-1:0]           row;
  logic [OFFSET_W-1:0]     luma_cnt;
  logic [CHROMA_IDX_W-1:0] chroma_index;

  logic row_end;
  logic frame_end;
  logic chroma_now;

  logic [23:0]             y_sum;
  logic [COMP_W-1:0]       y_q;
  logic [COMP_W-1:0]       red_q;
  logic [COMP_W-1:0]       blue_q;
  logic                    chroma_q;
  logic                    frame_end_q;
  logic [OFFSET_W-1:0]     luma_off_q;
  logic [CHROMA_IDX_W-1:0] chroma_idx_q;

  logic signed [9:0]  diff_b;
  logic signed [9:0]  diff_r;
  logic signed [27:0] prod_b;
  logic signed [27:0] prod_r;
  logic signed [11:0] cb_pre;
  logic signed [11:0] cr_pre;
  logic [COMP_W-1:0]  cb_q;
  logic [COMP_W-1:0]  cr_q;

  logic out_valid;
  logic slot_free;

  // configuration
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid &&
                     (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_FRAME_WIDTH) begin
        frame_width <= cfg.data;
      end else if (cfg.index == REG_FRAME_HEIGHT) begin
        frame_height <= cfg.data;
      end
    end
  end

  // effective even size, clamped to [2, MAX]
  assign w_ext = EWW'(frame_width);
  assign h_ext = EHW'(frame_height);

  always_comb begin
    w_clamp = w_ext;
    if (w_ext < EWW'(2)) begin
      w_clamp = EWW'(2);
    end else if (w_ext > EWW'(MAX_WIDTH)) begin
      w_clamp = EWW'(MAX_WIDTH);
    end
    h_clamp = h_ext;
    if (h_ext < EHW'(2)) begin
      h_clamp = EHW'(2);
    end else if (h_ext > EHW'(MAX_HEIGHT)) begin
      h_clamp = EHW'(MAX_HEIGHT);
    end
  end

  assign eff_w = {w_clamp[WW-1:1], 1'b0};
  assign eff_h = {h_clamp[HW-1:1], 1'b0};

  // plane bases, registered: area first, then cb_base and cr_base
  always_ff @(posedge clk) begin
    area    <= eff_w * eff_h;
    cb_base <= OFFSET_W'(area);
    cr_base <= OFFSET_W'(area) + OFFSET_W'(area >> 2);
  end

  // raster position
  assign row_end    = WW'(column) >= eff_w - WW'(1);
  assign frame_end  = row_end && (HW'(row) >= eff_h - HW'(1));
  assign chroma_now = !row[0] && !column[0];

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      column       <= '0;
      row          <= '0;
      luma_cnt     <= '0;
      chroma_index <= '0;
    end else if (cmd.load_pixel) begin
      if (chroma_now) begin
        chroma_index <= chroma_index + CHROMA_IDX_W'(1);
      end
      if (frame_end) begin
        column       <= '0;
        row          <= '0;
        luma_cnt     <= '0;
        chroma_index <= '0;
      end else if (row_end) begin
        column   <= '0;
        row      <= row + RW'(1);
        luma_cnt <= luma_cnt + OFFSET_W'(1);
      end else begin
        column   <= column + CLW'(1);
        luma_cnt <= luma_cnt + OFFSET_W'(1);
      end
    end
  end

  // luma at pixel transfer
  assign y_sum = K_Y_R * red + K_Y_G * green + K_Y_B * blue;

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      y_q          <= y_sum[23:16];
      red_q        <= red;
      blue_q       <= blue;
      chroma_q     <= chroma_now;
      frame_end_q  <= frame_end;
      luma_off_q   <= luma_cnt;
      chroma_idx_q <= chroma_index;
    end
  end

  // chroma from registered luma
  assign diff_b = $signed({2'b00, blue_q}) - $signed({2'b00, y_q});
  assign diff_r = $signed({2'b00, red_q}) - $signed({2'b00, y_q});
  assign prod_b = K_CB * diff_b;
  assign prod_r = K_CR * diff_r;
  assign cb_pre = 12'(prod_b >>> 16) + CHROMA_BIAS;
  assign cr_pre = 12'(prod_r >>> 16) + CHROMA_BIAS;

  always_ff @(posedge clk) begin
    if (cmd.load_chroma) begin
      cb_q <= clip_sample(cb_pre);
      cr_q <= clip_sample(cr_pre);
    end
  end

  // result register
  assign slot_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.out_sel)
        PLANE_CB: begin
          result.plane      <= PLANE_CB;
          result.offset     <= cb_base + OFFSET_W'(chroma_idx_q);
          result.sample     <= cb_q;
          result.last       <= 1'b0;
          result.frame_done <= 1'b0;
        end
        PLANE_CR: begin
          result.plane      <= PLANE_CR;
          result.offset     <= cr_base + OFFSET_W'(chroma_idx_q);
          result.sample     <= cr_q;
          result.last       <= 1'b1;
          result.frame_done <= frame_end_q;
        end
        default: begin
          result.plane      <= PLANE_Y;
          result.offset     <= luma_off_q;
          result.sample     <= y_q;
          result.last       <= !chroma_q;
          result.frame_done <= frame_end_q && !chroma_q;
        end
      endcase
    end
  end

  assign result.valid     = out_valid;
  assign status.chroma    = chroma_q;
  assign status.slot_free = slot_free;

endmodule

// File: rtl/rgb_to_ycbcr420_planar_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_ycbcr420_planar_unit
// Streaming RGB to YCbCr 4:2:0 (I420) converter with planar byte offsets.
// ----------------------------------------------------------------------------
// Pixels come in raster order; every pixel gives a luma transfer and the
// top-left pixel of each 2x2 block also gives Cb then Cr transfers, each
// carrying its byte offset in the planar frame. All results leave through
// one result register, so the controller issues one result at a time and
// holds while the sink stalls; a new pixel is taken with the last result
// of the previous pixel, or at once when the unit is idle. Writing
// frame_width or frame_height restarts the frame; sizes are clamped to
// [2, MAX] and forced even. A pixel may follow a size write on the next
// cycle; the plane bases settle before its chroma transfers go out.
// ----------------------------------------------------------------------------
module rgb_to_ycbcr420_planar_unit #(
  parameter int MAX_WIDTH  = ry420_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ry420_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic           clk,
  input  logic           rst,
  ry420_cfg_if.sink      cfg,
  ry420_pixel_if.sink    pixel,
  ry420_result_if.source result
);
  import ry420_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign pixel.ready = cmd.pixel_ready;

  ry420_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel.valid),
    .status      (status),
    .cmd         (cmd)
  );

  ry420_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .red    (pixel.red),
    .green  (pixel.green),
    .blue   (pixel.blue),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

  // a Cb transfer is always followed directly by its Cr sample
  a_cb_then_cr: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.plane == PLANE_CB) |=>
      (result.valid && result.plane == PLANE_CR))
    else $error("Cr sample does not follow Cb");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_done) |-> result.last)
    else $error("frame_done without last");

  a_cr_is_last: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.plane == PLANE_CR) |-> result.last)
    else $error("Cr sample not marked last");

  // no pixel is taken while a Cb sample waits in the result register
  a_no_accept_mid_chroma: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready && result.plane == PLANE_CB) |->
      !(pixel.valid && pixel.ready))
    else $error("pixel transfer during chroma sequence");

endmodule
